// ----- hw/rtl/nnfb_pkg.sv -----
// Shared types, constants and helpers for the nearest-neighbor flip blitter.
// No dependencies; imported by every module of the block.
package nnfb_pkg;

  localparam int SIZE_BITS          = 13;
  localparam int ORIGIN_BITS        = 12;
  localparam int BPP_BITS           = 3;
  localparam int ADDR_BITS          = 26;
  localparam int XY_BITS            = 13;
  localparam int COLOR_BITS         = 8;
  localparam int WORD_BITS          = 32;
  localparam int DIV_BITS           = 14;
  localparam int COORD_BITS_DEFAULT = 12;
  localparam int SIZE_MAX           = 4096;
  localparam int RED_SHIFT          = 16;
  localparam int GREEN_SHIFT        = 8;
  localparam int BLUE_SHIFT         = 0;
  localparam int QUEUE_DEPTH        = 2;
  localparam int CFG_ADDR_BITS      = 5;
  localparam int CFG_DATA_BITS      = 32;

  localparam logic REQ_PIXEL = 1'b1;
  localparam logic [BPP_BITS-1:0] BPP_24 = 3'd3;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_ORIGIN_X   = 3'd4,
    REG_ORIGIN_Y   = 3'd5,
    REG_BPP        = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                  req_type;
    logic [WORD_BITS-1:0]  pixel_word;
  } req_t;

  typedef struct packed {
    logic                   read_valid;
    logic [ADDR_BITS-1:0]   read_addr;
    logic                   write_valid;
    logic [XY_BITS-1:0]     write_x;
    logic [XY_BITS-1:0]     write_y;
    logic [COLOR_BITS-1:0]  red;
    logic [COLOR_BITS-1:0]  green;
    logic [COLOR_BITS-1:0]  blue;
    logic                   frame_done;
  } rsp_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0]   src_width;
    logic [SIZE_BITS-1:0]   src_height;
    logic [SIZE_BITS-1:0]   dst_width;
    logic [SIZE_BITS-1:0]   dst_height;
    logic [ORIGIN_BITS-1:0] origin_x;
    logic [ORIGIN_BITS-1:0] origin_y;
    logic [BPP_BITS-1:0]    pixel_bytes;
  } cfg_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [WORD_BITS-1:0]  word;
  } cmd_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_BITS-1:0]   dividend;
    logic [SIZE_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_BITS-1:0]   quotient;
    logic [SIZE_BITS-1:0]  remainder;
  } div_rsp_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [SIZE_BITS-1:0] size_of(input logic [SIZE_BITS-1:0] v);
    logic [SIZE_BITS-1:0] r;
    if (v == '0) begin
      r = SIZE_BITS'(1);
    end else if (v > SIZE_BITS'(SIZE_MAX)) begin
      r = SIZE_BITS'(SIZE_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/nnfb_front.sv -----
// Front end: accepts request transfers, classifies them and queues them.
// Depends on nnfb_pkg.
module nnfb_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  nnfb_pkg::req_t request,
  output logic           cmd_valid,
  input  logic           cmd_pop,
  output nnfb_pkg::cmd_t cmd
);
  import nnfb_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;
  cmd_t                cmd_in;

  assign full      = (count == CNT_BITS'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;
  assign cmd       = entries[rd_ptr];

  always_comb begin
    cmd_in.kind = (request.req_type == REQ_PIXEL) ? CMD_PIXEL : CMD_START;
    cmd_in.word = request.pixel_word;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(QUEUE_DEPTH))
    else $error("front queue count overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("back end popped an empty queue");

endmodule

// ----- hw/rtl/nnfb_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nnfb_pkg; shared by the column, row and rounding steps.
module nnfb_div (
  input  logic               clk,
  input  logic               rst,
  input  nnfb_pkg::div_req_t req,
  output nnfb_pkg::div_rsp_t rsp
);
  import nnfb_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_BITS);

  logic                 active;
  logic                 done;
  logic [CNT_BITS-1:0]  cnt;
  logic [DIV_BITS-1:0]  quo;
  logic [SIZE_BITS-1:0] rem;
  logic [SIZE_BITS-1:0] dvs;
  logic [SIZE_BITS:0]   partial;
  logic [SIZE_BITS:0]   diff;
  logic                 ge;

  assign partial = {rem, quo[DIV_BITS-1]};
  assign diff    = partial - {1'b0, dvs};
  assign ge      = !diff[SIZE_BITS];

  always_ff @(posedge clk) begin
    if (req.start && !active) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (active) begin
      rem <= ge ? diff[SIZE_BITS-1:0] : partial[SIZE_BITS-1:0];
      quo <= {quo[DIV_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !active) begin
        active <= 1'b1;
        cnt    <= CNT_BITS'(DIV_BITS - 1);
      end else if (active) begin
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !active)
    else $error("divider started while busy");

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(active) && !active)
    else $error("divider done without a run");

endmodule

// ----- hw/rtl/nnfb_back.sv -----
// Back end: destination walker, source address generation and result register.
// Depends on nnfb_pkg and nnfb_div.
module nnfb_back #(
  parameter int COORD_BITS = nnfb_pkg::COORD_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  nnfb_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  input  nnfb_pkg::cmd_t cmd,
  output logic           empty,
  input  logic           pop,
  output nnfb_pkg::rsp_t result
);
  import nnfb_pkg::*;

  localparam int CW        = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
  localparam int QW        = (COORD_BITS > DIV_BITS) ? COORD_BITS : DIV_BITS;
  localparam int SY_BITS   = SIZE_BITS - 1;
  localparam int PROD_BITS = SY_BITS + SIZE_BITS;
  localparam int SUM_BITS  = ((PROD_BITS > COORD_BITS) ? PROD_BITS : COORD_BITS) + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_STEP = 5'b00010,
    S_CEIL = 5'b00100,
    S_MUL  = 5'b01000,
    S_ADDR = 5'b10000
  } back_state_t;

  back_state_t           state;
  logic                  busy;
  logic                  step_row;
  logic [COORD_BITS-1:0] dest_col;
  logic [COORD_BITS-1:0] dest_row;
  logic [COORD_BITS-1:0] source_col;
  logic [SIZE_BITS-1:0]  row_step_count;
  logic [SIZE_BITS-1:0]  col_remainder;
  logic [SIZE_BITS-1:0]  row_remainder;
  logic [SY_BITS-1:0]    sy;
  logic [PROD_BITS-1:0]  prod;
  rsp_t                  pend;
  rsp_t                  out_data;
  logic                  out_valid;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  logic [SIZE_BITS-1:0]  sw, sh, dw, dh;
  logic                  col_end, row_end, last;
  logic                  bpp3;
  logic [CW:0]           x_sum, y_sum;
  rsp_t                  wr_fields;
  rsp_t                  done_fields;
  rsp_t                  emit_fields;
  logic [SIZE_BITS-1:0]  rr_next;
  logic [DIV_BITS-1:0]   ceil_rows;
  logic [DIV_BITS-1:0]   sh_m1;
  logic [SY_BITS-1:0]    sy_next;
  logic [SUM_BITS-1:0]   addr_sum;
  logic [ADDR_BITS-1:0]  addr_base;
  logic [ADDR_BITS-1:0]  addr;

  nnfb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    sw      = size_of(cfg.src_width);
    sh      = size_of(cfg.src_height);
    dw      = size_of(cfg.dst_width);
    dh      = size_of(cfg.dst_height);
    bpp3    = (cfg.pixel_bytes == BPP_24);
    col_end = CW'(dest_col) >= CW'(dw - 1'b1);
    row_end = CW'(dest_row) >= CW'(dh - 1'b1);
    last    = col_end && row_end;

    x_sum = (CW+1)'(cfg.origin_x) + (CW+1)'(dest_col);
    y_sum = (CW+1)'(cfg.origin_y) + (CW+1)'(dest_row);
    wr_fields             = '0;
    wr_fields.write_valid = 1'b1;
    wr_fields.write_x     = x_sum[XY_BITS-1:0];
    wr_fields.write_y     = y_sum[XY_BITS-1:0];
    wr_fields.red         = cmd.word[RED_SHIFT +: COLOR_BITS];
    wr_fields.green       = cmd.word[GREEN_SHIFT +: COLOR_BITS];
    wr_fields.blue        = cmd.word[BLUE_SHIFT +: COLOR_BITS];

    done_fields            = wr_fields;
    done_fields.frame_done = 1'b1;

    // ceil(row*sh/dh) from the row accumulator, then flip to bottom-up, clamped at 0
    rr_next   = step_row ? div_rsp.remainder : row_remainder;
    ceil_rows = DIV_BITS'(row_step_count) + DIV_BITS'(div_rsp.remainder != '0);
    sh_m1     = DIV_BITS'(sh - 1'b1);
    sy_next   = (ceil_rows >= sh_m1) ? '0 : SY_BITS'(sh_m1 - ceil_rows);

    addr_sum  = SUM_BITS'(prod) + SUM_BITS'(source_col);
    addr_base = addr_sum[ADDR_BITS-1:0];
    addr      = bpp3 ? ({addr_base[ADDR_BITS-2:0], 1'b0} + addr_base)
                     : {addr_base[ADDR_BITS-3:0], 2'b00};

    emit_fields            = pend;
    emit_fields.read_valid = 1'b1;
    emit_fields.read_addr  = addr;
  end

  always_comb begin
    cmd_pop          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = dh;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && !out_valid) begin
          cmd_pop = 1'b1;
          if (cmd.kind == CMD_START) begin
            div_req.start = 1'b1;
          end else if (busy && !last) begin
            div_req.start = 1'b1;
            if (col_end) begin
              div_req.dividend = DIV_BITS'(row_remainder) + DIV_BITS'(sh);
            end else begin
              div_req.dividend = DIV_BITS'(col_remainder) + DIV_BITS'(sw);
              div_req.divisor  = dw;
            end
          end
        end
      end
      S_STEP: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_BITS'(rr_next);
        end
      end
      S_CEIL, S_MUL, S_ADDR: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      busy           <= 1'b0;
      step_row       <= 1'b0;
      out_valid      <= 1'b0;
      dest_col       <= '0;
      dest_row       <= '0;
      source_col     <= '0;
      row_step_count <= '0;
      col_remainder  <= '0;
      row_remainder  <= '0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && !out_valid) begin
            if (cmd.kind == CMD_START) begin
              dest_col       <= '0;
              dest_row       <= '0;
              source_col     <= '0;
              row_step_count <= '0;
              col_remainder  <= '0;
              row_remainder  <= '0;
              busy           <= 1'b1;
              step_row       <= 1'b0;
              pend           <= '0;
              state          <= S_CEIL;
            end else if (!busy) begin
              out_data  <= '0;
              out_valid <= 1'b1;
            end else if (last) begin
              out_data       <= done_fields;
              out_valid      <= 1'b1;
              busy           <= 1'b0;
              dest_col       <= '0;
              dest_row       <= '0;
              source_col     <= '0;
              row_step_count <= '0;
              col_remainder  <= '0;
              row_remainder  <= '0;
            end else begin
              pend     <= wr_fields;
              step_row <= col_end;
              state    <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (div_rsp.done) begin
            if (step_row) begin
              dest_col       <= '0;
              source_col     <= '0;
              col_remainder  <= '0;
              dest_row       <= dest_row + 1'b1;
              row_step_count <= SIZE_BITS'(DIV_BITS'(row_step_count) + div_rsp.quotient);
              row_remainder  <= div_rsp.remainder;
            end else begin
              dest_col      <= dest_col + 1'b1;
              source_col    <= COORD_BITS'(QW'(source_col) + QW'(div_rsp.quotient));
              col_remainder <= div_rsp.remainder;
            end
            state <= S_CEIL;
          end
        end
        S_CEIL: begin
          if (div_rsp.done) begin
            sy    <= sy_next;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PROD_BITS'(sy) * PROD_BITS'(sw);
          state <= S_ADDR;
        end
        S_ADDR: begin
          out_data  <= emit_fields;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign empty  = !out_valid;
  assign result = out_data;

  a_emit_into_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADDR) |-> !out_valid)
    else $error("result register overwritten");

  a_done_has_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.frame_done) |-> (out_data.write_valid && !out_data.read_valid))
    else $error("frame end without its write");

endmodule

// ----- hw/rtl/nearest_neighbor_flip_blitter_unit.sv -----
// Nearest-neighbor scaling blitter with bottom-up source rows.
// Requests go in through a queue-style push/full port: req_type 0 starts a
// frame, req_type 1 hands over the source word fetched at the last issued
// read_addr. Each request produces exactly one result, taken from the
// empty/pop side: a read address for the next source pixel, a destination
// write (origin plus destination coordinates, red/green/blue), or both.
// frame_done marks the write of the last destination pixel; a pixel word
// while no frame runs yields an all-zero result.
// A start runs the shared one-bit-per-cycle divider once, for the rounding of
// the source row; a pixel runs it for the column or row step and again for
// the rounding. The last pixel of a frame and a pixel word while idle are
// answered without the divider. One item is in work at a time; a two-entry
// request queue keeps taking transfers meanwhile.
// When the receiver stalls the finished result holds and the walker waits.
// Reset clears the walker, the request queue and the registers (sizes 1,
// origins 0, 4 bytes per pixel). The user must write registers over the APB
// port between items only; the block itself does not enforce this.
// Depends on nnfb_pkg, nnfb_front, nnfb_back.
module nearest_neighbor_flip_blitter_unit #(
  parameter int COORD_BITS = nnfb_pkg::COORD_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  nnfb_pkg::req_t                     request,
  output logic                               empty,
  input  logic                               pop,
  output nnfb_pkg::rsp_t                     result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nnfb_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [nnfb_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [nnfb_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import nnfb_pkg::*;

  cfg_t     cfg;
  cfg_reg_t reg_idx;
  logic     cfg_write;
  logic     cmd_valid;
  logic     cmd_pop;
  cmd_t     cmd;

  assign pready    = 1'b1;
  assign reg_idx   = cfg_reg_t'(paddr[CFG_ADDR_BITS-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width   <= SIZE_BITS'(1);
      cfg.src_height  <= SIZE_BITS'(1);
      cfg.dst_width   <= SIZE_BITS'(1);
      cfg.dst_height  <= SIZE_BITS'(1);
      cfg.origin_x    <= '0;
      cfg.origin_y    <= '0;
      cfg.pixel_bytes <= BPP_BITS'(4);
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_SRC_WIDTH:  cfg.src_width   <= pwdata[SIZE_BITS-1:0];
        REG_SRC_HEIGHT: cfg.src_height  <= pwdata[SIZE_BITS-1:0];
        REG_DST_WIDTH:  cfg.dst_width   <= pwdata[SIZE_BITS-1:0];
        REG_DST_HEIGHT: cfg.dst_height  <= pwdata[SIZE_BITS-1:0];
        REG_ORIGIN_X:   cfg.origin_x    <= pwdata[ORIGIN_BITS-1:0];
        REG_ORIGIN_Y:   cfg.origin_y    <= pwdata[ORIGIN_BITS-1:0];
        REG_BPP:        cfg.pixel_bytes <= pwdata[BPP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SRC_WIDTH:  prdata = CFG_DATA_BITS'(cfg.src_width);
      REG_SRC_HEIGHT: prdata = CFG_DATA_BITS'(cfg.src_height);
      REG_DST_WIDTH:  prdata = CFG_DATA_BITS'(cfg.dst_width);
      REG_DST_HEIGHT: prdata = CFG_DATA_BITS'(cfg.dst_height);
      REG_ORIGIN_X:   prdata = CFG_DATA_BITS'(cfg.origin_x);
      REG_ORIGIN_Y:   prdata = CFG_DATA_BITS'(cfg.origin_y);
      REG_BPP:        prdata = CFG_DATA_BITS'(cfg.pixel_bytes);
      default:        prdata = '0;
    endcase
  end

  nnfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  nnfb_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
